>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the enumerator, kce_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/kce_pkg.sv
// Package of the k-combination enumerator: widths, register indexes and the
// structs passed between cells, the output buffer and the top level. No dependencies.
`default_nettype none

package kce_pkg;

	localparam int VALUE_BITS   = 6;
	localparam int PICK_BITS    = 4;
	localparam int NUM_SLOTS    = 8;
	localparam int MAX_PICK_DEF = 8;

	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_W   = 6;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = NUM_SLOTS * VALUE_BITS;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SET_SIZE   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PICK_COUNT = 1'b1;

	// Data handed from a cell to its right neighbor.
	typedef struct packed {
		logic                  fill;
		logic [VALUE_BITS-1:0] val;
	} link_t;

	// Update command common to all cells.
	typedef struct packed {
		logic load;
		logic clear;
	} cell_ctrl_t;

	// Per-cell status collected by the top level.
	typedef struct packed {
		logic grow;
		logic near;
		logic pivot;
	} cell_stat_t;

	// One result item.
	typedef struct packed {
		logic                                  valid;
		logic                                  fin;
		logic [NUM_SLOTS-1:0][VALUE_BITS-1:0]  elem;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/kce_cell.sv
// One element cell of the enumerator chain: holds one element of the
// current combination. Depends on kce_pkg.
`default_nettype none

module kce_cell #(
	parameter int IDX = 0
) (
	input  wire logic                           clk,
	input  wire kce_pkg::cell_ctrl_t            ctrl,
	input  wire logic [kce_pkg::VALUE_BITS-1:0] n,
	input  wire logic [kce_pkg::PICK_BITS-1:0]  k,
	input  wire kce_pkg::link_t                 link_in,
	output kce_pkg::link_t                      link_out,
	input  wire logic                           grow_right_in,
	output logic                                grow_right_out,
	output kce_pkg::cell_stat_t                 stat
);
	import kce_pkg::*;

	localparam logic [PICK_BITS-1:0]  IDX_K  = PICK_BITS'(IDX);
	localparam logic [VALUE_BITS-1:0] IDX_P1 = VALUE_BITS'(IDX + 1);

	logic [VALUE_BITS-1:0] cur_q;
	logic [VALUE_BITS-1:0] limit;
	logic [VALUE_BITS-1:0] cur_inc;
	logic [VALUE_BITS-1:0] nv;
	logic                  active;
	logic                  grow;
	logic                  pivot;

	// Largest value this position may hold: n - k + 1 + IDX.
	assign active  = IDX_K < k;
	assign limit   = VALUE_BITS'(n - VALUE_BITS'(k) + IDX_P1);
	assign cur_inc = VALUE_BITS'(cur_q + VALUE_BITS'(1));
	assign grow    = active && (cur_q < limit);
	assign pivot   = grow && !grow_right_in;

	always_comb begin
		if (!active) begin
			nv = '0;
		end else if (link_in.fill) begin
			nv = VALUE_BITS'(link_in.val + VALUE_BITS'(1));
		end else if (pivot) begin
			nv = cur_inc;
		end else begin
			nv = cur_q;
		end
	end

	assign link_out.fill  = link_in.fill | pivot;
	assign link_out.val   = nv;
	assign grow_right_out = grow_right_in | grow;
	assign stat.grow      = grow;
	assign stat.near      = active && (cur_inc == limit);
	assign stat.pivot     = pivot;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			cur_q <= '0;
		end else if (ctrl.load) begin
			cur_q <= nv;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/kce_out_skid.sv
// Two-entry output buffer of the enumerator: main register plus skid register,
// so the input side keeps a registered ready. Depends on kce_pkg.
`default_nettype none

module kce_out_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               push_ready,
	input  wire kce_pkg::res_t push_res,
	output logic               out_valid,
	input  wire logic          out_ready,
	output kce_pkg::res_t      out_res
);
	import kce_pkg::*;

	logic main_vld_q;
	logic skid_vld_q;
	res_t main_q;
	res_t skid_q;

	assign push_ready = !skid_vld_q;
	assign out_valid  = main_vld_q;
	assign out_res    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ready || !main_vld_q) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_vld_q) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push && !skid_vld_q) begin
			skid_q <= push_res;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/k_combination_enumerator_unit.sv
// Top level of the k-combination enumerator: configuration registers, the
// chain of element cells and the output buffer. Depends on kce_pkg, kce_cell
// and kce_out_skid.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[0] restart, tdata[7:1] zero
//   m_axis    out  tvalid/tready          tdata elem_0..elem_7, tuser valid_res,
//                                         tlast final_res
//   cfg       in   cfg_we (no wait)       cfg_index, cfg_wdata
//
// One request per cycle while s_axis_tready is high: a request is turned into
// its combination in the cycle it is transferred, by one pass through the cell
// chain (rightmost growable cell found on the right-to-left chain, refill on the
// left-to-right chain), and the result is registered in the output buffer.
// Reset clears the control flags and loads the register defaults n=4, k=2.
// s_axis_tready drops only when both output buffer entries are full.
`default_nettype none

module k_combination_enumerator_unit #(
	parameter int MAX_PICK = kce_pkg::MAX_PICK_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [kce_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] restart
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [kce_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // elem_0 .. elem_7
	output logic                                  m_axis_tuser,  // valid_res
	output logic                                  m_axis_tlast,  // final_res
	input  wire logic                             cfg_we,
	input  wire logic [kce_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [kce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import kce_pkg::*;

	logic [VALUE_BITS-1:0] set_size_q;
	logic [PICK_BITS-1:0]  pick_count_q;
	logic                  started_q;

	logic                  acc;
	logic                  restart_eff;
	logic                  pick_ok;
	logic                  res_valid;
	logic                  res_final;
	logic                  final_next;
	cell_ctrl_t            ctrl;
	res_t                  res;

	link_t                 link  [MAX_PICK+1];
	logic [MAX_PICK:0]     grow_r;
	logic [MAX_PICK-1:0]   grow_vec;
	logic [MAX_PICK-1:0]   near_vec;
	logic [MAX_PICK-1:0]   pivot_vec;
	cell_stat_t            stat  [MAX_PICK];
	res_t                  out_res;

	assign acc = s_axis_tvalid && s_axis_tready;

	// A request before any restart, or after a register write, starts anew.
	assign restart_eff = s_axis_tdata[0] || !started_q;
	assign pick_ok     = (pick_count_q <= PICK_BITS'(MAX_PICK))
		&& (VALUE_BITS'(pick_count_q) <= set_size_q);

	// Configuration writes; each one also drops the running enumeration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   <= VALUE_BITS'(4);
			pick_count_q <= PICK_BITS'(2);
			started_q    <= 1'b0;
		end else if (cfg_we) begin
			started_q <= 1'b0;
			case (cfg_index)
				CFG_SET_SIZE: begin
					set_size_q <= cfg_wdata[VALUE_BITS-1:0];
				end
				CFG_PICK_COUNT: begin
					pick_count_q <= cfg_wdata[PICK_BITS-1:0];
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			started_q <= 1'b1;
		end
	end

	// Cell chain: fill enters from the left on restart, grow runs right to left.
	assign link[0].fill      = restart_eff;
	assign link[0].val       = '0;
	assign grow_r[MAX_PICK]  = 1'b0;

	generate
		for (genvar i = 0; i < MAX_PICK; i++) begin : g_cell
			kce_cell #(
				.IDX (i)
			) u_cell (
				.clk            (clk),
				.ctrl           (ctrl),
				.n              (set_size_q),
				.k              (pick_count_q),
				.link_in        (link[i]),
				.link_out       (link[i+1]),
				.grow_right_in  (grow_r[i+1]),
				.grow_right_out (grow_r[i]),
				.stat           (stat[i])
			);
			assign grow_vec[i]  = stat[i].grow;
			assign near_vec[i]  = stat[i].near;
			assign pivot_vec[i] = stat[i].pivot;
		end
	endgenerate

	// The step yields the last combination when the pivot is the only
	// growable cell and it reaches its limit with this increment.
	assign final_next = (|(pivot_vec & near_vec)) && (grow_vec == pivot_vec);

	// The first combination is also the last when k equals n or the pick is empty.
	always_comb begin
		if (restart_eff) begin
			res_valid = pick_ok;
			res_final = pick_ok && ((pick_count_q == '0)
				|| (VALUE_BITS'(pick_count_q) == set_size_q));
		end else begin
			res_valid = pick_ok && grow_r[0];
			res_final = pick_ok && grow_r[0] && final_next;
		end
	end

	// Load the cells on a good step; clear them on a restart that gives nothing.
	assign ctrl.load  = acc && res_valid;
	assign ctrl.clear = acc && restart_eff && !pick_ok;

	always_comb begin
		res.valid = res_valid;
		res.fin   = res_final;
		res.elem  = '0;
		for (int s = 0; s < MAX_PICK; s++) begin
			res.elem[s] = res_valid ? link[s+1].val : '0;
		end
	end

	kce_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (acc),
		.push_ready (s_axis_tready),
		.push_res   (res),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = out_res.elem;
	assign m_axis_tuser = out_res.valid;
	assign m_axis_tlast = out_res.fin;

endmodule

`default_nettype wire

>>> hw/rtl/kce_checker.sv
// Port-level checker of the k-combination enumerator, bound to the top level.
// Depends on kce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kce_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [kce_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input wire logic                             m_axis_tuser,
	input wire logic                             m_axis_tlast
);

	// An empty result carries no elements and no final mark.
	`KCE_ASSERT_IMP(a_empty_zero, clk, arst_n,
		m_axis_tvalid && !m_axis_tuser, !m_axis_tlast && m_axis_tdata == '0,
		"empty result with data or final mark")

	// Only a real combination can be the last one.
	`KCE_ASSERT_IMP(a_final_valid, clk, arst_n,
		m_axis_tvalid && m_axis_tlast, m_axis_tuser,
		"final mark on empty result")

	// Input stalls only while a result is waiting at the output.
	`KCE_ASSERT_IMP(a_stall_cause, clk, arst_n,
		!s_axis_tready, m_axis_tvalid,
		"input stalled with output empty")

	// A stalled result holds.
	`KCE_ASSERT_NXT(a_out_hold, clk, arst_n,
		m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata),
		"stalled result changed")

endmodule

bind k_combination_enumerator_unit kce_checker u_kce_checker (.*);

`default_nettype wire

>>> sim/kce_subset_checker.sv
// Checker for the k-combination enumerator: watches the request, result and
// register-write ports, predicts each combination and compares it on arrival.
// Depends on kce_pkg.

module kce_subset_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	input  wire logic                             s_axis_tready,
	input  wire logic [kce_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] restart
	input  wire logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic [kce_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // elem_0 .. elem_7
	input  wire logic                             m_axis_tuser,  // valid_res
	input  wire logic                             m_axis_tlast,  // final_res
	input  wire logic                             cfg_we,
	input  wire logic [kce_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [kce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    result_count,
	output int                                    combo_count,
	output int                                    final_count
);
	import kce_pkg::*;

	localparam int PICK_LIMIT = MAX_PICK_DEF;

	logic [VALUE_BITS-1:0] subset [NUM_SLOTS];
	logic [VALUE_BITS-1:0] set_size;
	logic [PICK_BITS-1:0]  pick_count;
	logic                  started;
	logic                  exhausted;
	res_t                  subset_q [$];
	int                    mismatches;
	int                    seen_results;
	int                    seen_combos;
	int                    seen_finals;

	assign fail_count   = mismatches;
	assign result_count = seen_results;
	assign combo_count  = seen_combos;
	assign final_count  = seen_finals;

	// True when each of the first k slots sits at its highest possible value.
	function automatic logic at_last(input int n, input int k);
		for (int i = 0; i < k; i++)
			if (int'(subset[i]) != n - k + 1 + i)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic res_t advance_subset(input logic restart_req);
		res_t r;
		int   n;
		int   k;
		int   pos;
		logic grown;
		r     = '0;
		n     = int'(set_size);
		k     = int'(pick_count);
		grown = 1'b0;
		if (restart_req || !started) begin
			started = 1'b1;
			for (int i = 0; i < NUM_SLOTS; i++)
				subset[i] = '0;
			if (k <= PICK_LIMIT && k <= n) begin
				for (int i = 0; i < k; i++)
					subset[i] = VALUE_BITS'(i + 1);
				grown = 1'b1;
			end
		end else if (!exhausted && k <= PICK_LIMIT && k <= n) begin
			// bump the rightmost slot with headroom, refill the tail
			pos = k - 1;
			while (pos >= 0 && !grown) begin
				if (int'(subset[pos]) < n - k + 1 + pos) begin
					subset[pos] = subset[pos] + 1'b1;
					for (int j = pos + 1; j < k; j++)
						subset[j] = subset[j-1] + 1'b1;
					grown = 1'b1;
				end
				pos--;
			end
		end
		if (!grown) begin
			exhausted = 1'b1;
			return r;
		end
		exhausted = at_last(n, k);
		r.valid   = 1'b1;
		r.fin     = exhausted;
		for (int i = 0; i < k; i++)
			r.elem[i] = subset[i];
		return r;
	endfunction

	task automatic report(input string field, input logic [VALUE_BITS-1:0] want,
			input logic [VALUE_BITS-1:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			set_size   <= VALUE_BITS'(4);
			pick_count <= PICK_BITS'(2);
			started    <= 1'b0;
			exhausted  <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++)
				subset[i] <= '0;
			subset_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SET_SIZE)
					set_size = cfg_wdata[VALUE_BITS-1:0];
				else
					pick_count = cfg_wdata[PICK_BITS-1:0];
				started   = 1'b0;
				exhausted = 1'b0;
			end
			if (s_axis_tvalid && s_axis_tready)
				subset_q.insert(subset_q.size(), advance_subset(s_axis_tdata[0]));
			if (m_axis_tvalid && m_axis_tready) begin
				seen_results++;
				if (m_axis_tuser === 1'b1)
					seen_combos++;
				if (m_axis_tlast === 1'b1)
					seen_finals++;
				if (subset_q.size() == 0) begin
					$display("%0t: result with nothing expected, got valid %b final %b elems %h",
						$realtime, m_axis_tuser, m_axis_tlast, m_axis_tdata);
					mismatches++;
				end else begin
					want = subset_q.pop_front();
					if (m_axis_tuser !== want.valid)
						report("valid_res", VALUE_BITS'(want.valid), VALUE_BITS'(m_axis_tuser));
					if (m_axis_tlast !== want.fin)
						report("final_res", VALUE_BITS'(want.fin), VALUE_BITS'(m_axis_tlast));
					for (int i = 0; i < NUM_SLOTS; i++)
						if (m_axis_tdata[i*VALUE_BITS +: VALUE_BITS] !== want.elem[i])
							report($sformatf("elem_%0d", i), want.elem[i],
								m_axis_tdata[i*VALUE_BITS +: VALUE_BITS]);
				end
			end
			pending <= subset_q.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// Top of the enumerator testbench: clock, reset, request and register-write
// stimulus, output back-pressure, watchdog and verdict.
// Depends on kce_pkg, k_combination_enumerator_unit and kce_subset_checker.

module tb_top;
	import kce_pkg::*;

	// Pacing of the two streams; each phase of the run uses one of these.
	typedef enum int {
		PACE_FREE,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_e;

	localparam int RAND_ITEMS  = 900;
	// Cycles without any transfer or write before the run is declared hung.
	localparam int STALL_LIMIT = 4000;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [0] restart, rest zero
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // elem_0 .. elem_7
	logic                    m_axis_tuser;   // valid_res
	logic                    m_axis_tlast;   // final_res
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int sent;
	int settings;
	int quiet_cycles;
	int fail_count;
	int pending;
	int result_count;
	int combo_count;
	int final_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	k_combination_enumerator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	kce_subset_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count),
		.combo_count   (combo_count),
		.final_count   (final_count)
	);

	// Random back-pressure on the result stream, redrawn every cycle.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Watchdog: restart the count on any transfer or register write.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$realtime, STALL_LIMIT, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_pace(input pace_e pace);
		case (pace)
			PACE_FREE: begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			PACE_SRC_IDLE: begin
				src_idle_pct  = 73;
				snk_stall_pct = 0;
			end
			PACE_SNK_STALL: begin
				src_idle_pct  = 0;
				snk_stall_pct = 73;
			end
			default: begin
				src_idle_pct  = 15;
				snk_stall_pct = 15;
			end
		endcase
	endtask

	// Offer one request, with a random idle gap ahead of it, and hold it
	// until the transfer happens. Valid stays high afterwards so that
	// back-to-back requests follow without a gap.
	task automatic push_request(input logic restart_bit);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart_bit};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
	endtask

	// Drop valid and wait until every expected result is back, then let the
	// output buffer settle.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Write n and k in random order while the block is idle. The pick count
	// register is narrower than the write data, so the upper bits get noise.
	task automatic configure(input int n, input int k);
		logic [CFG_DATA_W-1:0] k_word;
		drain();
		k_word = CFG_DATA_W'($urandom_range(0, 63));
		k_word[PICK_BITS-1:0] = PICK_BITS'(k);
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_SET_SIZE, CFG_DATA_W'(n));
			write_reg(CFG_PICK_COUNT, k_word);
		end else begin
			write_reg(CFG_PICK_COUNT, k_word);
			write_reg(CFG_SET_SIZE, CFG_DATA_W'(n));
		end
		settings++;
	endtask

	initial begin : stimulus
		int target;
		int phase;
		int kind;
		int n;
		int k;
		int len;
		int odds;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		sent          = 0;
		settings      = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling.
		set_pace(PACE_FREE);
		// Reset defaults n=4, k=2: a first next acts as restart, walk all six
		// pairs, run past the end, then restart.
		repeat (7) push_request(1'b0);
		push_request(1'b1);
		// Empty pick: one valid, final, all-zero result, then nothing.
		configure(4, 0);
		push_request(1'b1);
		push_request(1'b0);
		// k above n: no combination, even for a fresh next.
		configure(2, 3);
		push_request(1'b0);
		push_request(1'b0);
		// k above the slot count, including the largest register value.
		configure(20, 9);
		push_request(1'b1);
		configure(20, 15);
		push_request(1'b1);
		// Largest n with all slots used; a write restarts the enumeration.
		configure(63, 8);
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b1);
		// Single combination that is also the last one.
		configure(8, 8);
		push_request(1'b1);
		push_request(1'b0);
		// Empty set with a nonzero pick.
		configure(0, 1);
		push_request(1'b1);

		// Random phases: short enumerations that run to the end most of the
		// time, plus long walks at large n that drive high element values.
		target = sent + RAND_ITEMS;
		phase  = 0;
		while (sent < target) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				n    = $urandom_range(0, 10);
				k    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, (n < MAX_PICK_DEF) ? n : MAX_PICK_DEF);
				len  = $urandom_range(10, 40);
				odds = 12;
			end else if (kind < 9) begin
				n    = $urandom_range(32, 63);
				k    = $urandom_range(1, MAX_PICK_DEF);
				len  = $urandom_range(60, 90);
				odds = 80;
			end else begin
				n    = 63;
				k    = $urandom_range(0, 1) ? 1 : MAX_PICK_DEF;
				len  = 72;
				odds = 1000;
			end
			configure(n, k);
			set_pace(pace_e'(phase % 4));
			for (int i = 0; i < len && sent < target; i++)
				push_request($urandom_range(0, odds - 1) == 0);
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d requests over %0d register settings after reset defaults",
			sent, settings);
		$display("Checked %0d results: %0d carried a combination, %0d marked final",
			result_count, combo_count, final_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kce_pkg.sv
hw/rtl/kce_cell.sv
hw/rtl/kce_out_skid.sv
hw/rtl/k_combination_enumerator_unit.sv
hw/rtl/kce_checker.sv
sim/kce_subset_checker.sv
sim/tb_top.sv
